// ===== sv/gbba_pkg.sv =====
// Shared constants, codes and types for the three-pass box blur.
package gbba_pkg;

  localparam int MAX_WIDTH_DEF   = 256;
  localparam int MAX_HEIGHT_DEF  = 256;
  localparam int SAMPLE_BITS_DEF = 24;

  localparam int WEIGHT_BITS = 18;
  localparam int WEIGHT_FRAC = 16;
  localparam int RAD_BITS    = 7;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 9;

  localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = WEIGHT_BITS'(1) << WEIGHT_FRAC;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_RAD_A  = 3'd2,
    REG_RAD_B  = 3'd3,
    REG_RAD_C  = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_FETCH = 1'b1
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_LINE,
    ST_INIT_MUL,
    ST_INIT_ACC,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_ADD_RD,
    ST_SUB_RD,
    ST_LINE_END,
    ST_RAT_RD,
    ST_RAT_CHK,
    ST_RAT_DIV
  } state_e;

endpackage

// ===== sv/gbba_if.sv =====
// Handshake channels: sample/fetch input, result output, register write.
interface gbba_in_if #(parameter int SAMPLE_BITS = gbba_pkg::SAMPLE_BITS_DEF);
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          sample_valid;
  logic                          load_last;

  modport source (output valid, func, sample, sample_valid, load_last, input ready);
  modport sink   (input valid, func, sample, sample_valid, load_last, output ready);
endinterface

interface gbba_out_if #(parameter int SAMPLE_BITS = gbba_pkg::SAMPLE_BITS_DEF);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] blurred;
  logic                          out_valid;
  logic                          out_last;

  modport source (output valid, blurred, out_valid, out_last, input ready);
  modport sink   (input valid, blurred, out_valid, out_last, output ready);
endinterface

interface gbba_cfg_if;
  import gbba_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/gaussian_blur_box_approx.sv =====
// Three-pass box blur over a raster held in memory, with a weight plane for missing samples.
// Load: a word is taken whenever idle. Fetch: memory read, then registered result word; the
// next fetch is taken back in idle. Blur run after the last load: each pass touches every
// cell once per direction, each through the bit-serial divider; the passes repeat on the
// weight plane, plus one ratio sweep, when any sample is missing. Input stalls in the run.
// Reset clears control, registers and indexes; memories are not cleared.
module gaussian_blur_box_approx #(
  parameter int MAX_WIDTH   = gbba_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = gbba_pkg::MAX_HEIGHT_DEF,
  parameter int SAMPLE_BITS = gbba_pkg::SAMPLE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gbba_in_if.sink    in_i,
  gbba_out_if.source out_o,
  gbba_cfg_if.sink   cfg_i
);
  import gbba_pkg::*;

  localparam int SB   = SAMPLE_BITS;
  localparam int WB   = WEIGHT_BITS;
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int WH   = $clog2(MAX_HEIGHT + 1);
  localparam int LW   = (WW > WH) ? WW : WH;
  localparam int AW   = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int NW   = AW + 1;
  localparam int KW   = ((LW > RAD_BITS) ? LW : RAD_BITS) + 2;
  localparam int VW   = (SB > WB) ? SB : WB;
  localparam int SW   = VW + RAD_BITS + 2;
  localparam int DNW0 = SB + WEIGHT_FRAC + 1;
  localparam int DNW  = (DNW0 > SW + 1) ? DNW0 : SW + 1;

  localparam logic [DNW-1:0] SAT_POS = {{(DNW-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic [DNW-1:0] SAT_NEG = {{(DNW-SB){1'b0}}, 1'b1, {(SB-1){1'b0}}};
  localparam logic [SB-1:0]  SMAX    = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-1:0]  SMIN    = {1'b1, {(SB-1){1'b0}}};

  // configuration
  logic [CFG_DATA_W-1:0] width_q, height_q;
  logic [RAD_BITS-1:0]   ra_q, rb_q, rc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_DATA_W'(256);
      height_q <= CFG_DATA_W'(256);
      ra_q     <= '0;
      rb_q     <= '0;
      rc_q     <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_WIDTH:  width_q  <= cfg_i.data;
        REG_HEIGHT: height_q <= cfg_i.data;
        REG_RAD_A:  ra_q     <= cfg_i.data[RAD_BITS-1:0];
        REG_RAD_B:  rb_q     <= cfg_i.data[RAD_BITS-1:0];
        REG_RAD_C:  rc_q     <= cfg_i.data[RAD_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;

  // control registers
  state_e               state_q, state_d;
  logic                 plane_q, plane_d, vert_q, vert_d;
  logic [1:0]           pass_q, pass_d;
  logic [LW-1:0]        line_q, line_d, x_q, x_d;
  logic [AW-1:0]        base_q, base_d;
  logic [RAD_BITS:0]    j_q, j_d;
  logic [NW-1:0]        cnt_q, cnt_d, load_idx_q, load_idx_d, read_idx_q, read_idx_d;
  logic                 any_inv_q, any_inv_d, neg_q, neg_d;
  logic                 out_full_q, out_full_d, fetch_last_q, fetch_last_d;
  // datapath registers
  logic signed [SW-1:0] sum_q, sum_d;
  logic signed [VW-1:0] a_q, a_d, res_q, res_d;
  logic signed [SB-1:0] blurred_q;
  logic                 out_ok_q, out_last_q;

  // effective raster size and radius
  logic [WW-1:0]    w_s;
  logic [WH-1:0]    h_s;
  logic [WW+WH-1:0] area_s;
  logic [NW-1:0]    n_s;
  logic [LW-1:0]    wl, hl, dmin, rmax_s, len_s, lines_s, stride_s, last_s;
  logic [RAD_BITS-1:0] rsel, r_s;
  logic [RAD_BITS:0]   rp1;

  always_comb begin
    if (width_q == '0) begin
      w_s = WW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_s = WW'(MAX_WIDTH);
    end else begin
      w_s = WW'(width_q);
    end
    if (height_q == '0) begin
      h_s = WH'(1);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      h_s = WH'(MAX_HEIGHT);
    end else begin
      h_s = WH'(height_q);
    end
  end

  assign area_s = w_s * h_s;
  assign n_s    = NW'(area_s);
  assign wl     = LW'(w_s);
  assign hl     = LW'(h_s);
  assign dmin   = (wl < hl) ? wl : hl;
  assign rmax_s = (dmin - LW'(1)) >> 1;

  always_comb begin
    case (pass_q)
      2'd0:    rsel = ra_q;
      2'd1:    rsel = rb_q;
      default: rsel = rc_q;
    endcase
    r_s = (KW'(rsel) > KW'(rmax_s)) ? RAD_BITS'(rmax_s) : rsel;
  end

  assign rp1      = {1'b0, r_s} + (RAD_BITS+1)'(1);
  assign len_s    = vert_q ? hl : wl;
  assign lines_s  = vert_q ? wl : hl;
  assign stride_s = vert_q ? wl : LW'(1);
  assign last_s   = len_s - LW'(1);

  // position along the current line, then cell address
  logic [KW-1:0]   k_add, k_sub, k_j, k_w;
  logic [LW-1:0]   k_s;
  logic [2*LW-1:0] kprod;
  logic [AW-1:0]   addr_s;

  always_comb begin
    k_add = KW'(x_q) + KW'(r_s) + KW'(1);
    k_sub = (KW'(x_q) >= KW'(r_s)) ? (KW'(x_q) - KW'(r_s)) : '0;
    k_j   = (state_q == ST_INIT_MUL) ? KW'(1) : KW'(j_q) + KW'(1);
    case (state_q)
      ST_INIT_MUL, ST_INIT_ACC: k_w = k_j;
      ST_DIV_WAIT:              k_w = k_add;
      ST_ADD_RD:                k_w = k_sub;
      ST_SUB_RD:                k_w = KW'(x_q);
      default:                  k_w = '0;
    endcase
    k_s = (k_w > KW'(last_s)) ? last_s : LW'(k_w);
  end

  assign kprod  = k_s * stride_s;
  assign addr_s = base_q + AW'(kprod);

  // memories
  logic [SB-1:0]        img_rdata, scr_rdata, img_wdata;
  logic [WB-1:0]        wt_rdata, ws_rdata, wt_wdata;
  logic                 inv_rdata;
  logic signed [SB-1:0] img_rd, scr_rd;
  logic                 img_we, scr_we, wt_we, ws_we, inv_we, load_we, box_we, rat_we;
  logic [AW-1:0]        waddr, raddr;
  logic [NW-1:0]        fetch_idx;
  logic                 fetch_last;
  logic                 in_ready, in_acc, is_fetch;
  logic [SB-1:0]        rat_val, load_val;

  assign img_rd = img_rdata;
  assign scr_rd = scr_rdata;

  gbba_ram #(.DATA_W(SB), .ADDR_W(AW)) u_image (
    .clk_i, .we_i(img_we), .waddr_i(waddr), .wdata_i(img_wdata),
    .raddr_i(raddr), .rdata_o(img_rdata)
  );
  gbba_ram #(.DATA_W(SB), .ADDR_W(AW)) u_scratch (
    .clk_i, .we_i(scr_we), .waddr_i(waddr), .wdata_i(res_q[SB-1:0]),
    .raddr_i(raddr), .rdata_o(scr_rdata)
  );
  gbba_ram #(.DATA_W(WB), .ADDR_W(AW)) u_weight (
    .clk_i, .we_i(wt_we), .waddr_i(waddr), .wdata_i(wt_wdata),
    .raddr_i(raddr), .rdata_o(wt_rdata)
  );
  gbba_ram #(.DATA_W(WB), .ADDR_W(AW)) u_wscratch (
    .clk_i, .we_i(ws_we), .waddr_i(waddr), .wdata_i(res_q[WB-1:0]),
    .raddr_i(raddr), .rdata_o(ws_rdata)
  );
  gbba_ram #(.DATA_W(1), .ADDR_W(AW)) u_invalid (
    .clk_i, .we_i(inv_we), .waddr_i(waddr), .wdata_i(!in_i.sample_valid),
    .raddr_i(raddr), .rdata_o(inv_rdata)
  );

  // source word of the current box line
  logic signed [VW-1:0] src_v;

  always_comb begin
    if (plane_q) begin
      src_v = vert_q ? VW'(ws_rdata) : VW'(wt_rdata);
    end else begin
      src_v = vert_q ? VW'(scr_rd) : VW'(img_rd);
    end
  end

  // divider
  logic             div_start, div_busy, div_done;
  logic [DNW-1:0]   div_num, div_quo, neg_quo;
  logic [WB-1:0]    div_den;
  logic [SW-1:0]    mag_s;
  logic signed [SB:0] vx;
  logic [SB:0]      vmag;
  logic signed [VW-1:0] box_res;

  assign mag_s   = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
  assign vx      = (SB+1)'(img_rd);
  assign vmag    = vx[SB] ? (SB+1)'(-vx) : (SB+1)'(vx);
  assign neg_quo = -div_quo;
  assign box_res = neg_q ? -VW'(div_quo) : VW'(div_quo);

  always_comb begin
    if (state_q == ST_RAT_CHK) begin
      div_num = (DNW'(vmag) << WEIGHT_FRAC) + DNW'(wt_rdata >> 1);
      div_den = wt_rdata;
    end else begin
      div_num = DNW'(mag_s) + DNW'(r_s);
      div_den = WB'({r_s, 1'b1});
    end
    if (!neg_q) begin
      rat_val = (div_quo > SAT_POS) ? SMAX : div_quo[SB-1:0];
    end else begin
      rat_val = (div_quo > SAT_NEG) ? SMIN : neg_quo[SB-1:0];
    end
    if (state_q == ST_RAT_CHK) begin
      rat_val = '0;
    end
  end

  gbba_div #(.NUM_W(DNW), .DEN_W(WB)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .busy_o(div_busy), .done_o(div_done), .quo_o(div_quo)
  );

  // handshake and addressing
  assign is_fetch   = (in_i.func == FUNC_FETCH);
  assign in_ready   = (state_q == ST_IDLE) && (!is_fetch || !out_full_q || out_o.ready);
  assign in_acc     = in_i.valid && in_ready;
  assign fetch_idx  = (read_idx_q >= n_s) ? '0 : read_idx_q;
  assign fetch_last = (fetch_idx == n_s - NW'(1));
  assign load_val   = in_i.sample_valid ? in_i.sample : '0;

  assign load_we = in_acc && !is_fetch && (load_idx_q < n_s);
  assign box_we  = (state_q == ST_SUB_RD);
  assign rat_we  = ((state_q == ST_RAT_CHK) && (inv_rdata || wt_rdata == '0))
                || ((state_q == ST_RAT_DIV) && div_done);
  assign img_we  = load_we || (box_we && !plane_q && vert_q) || rat_we;
  assign scr_we  = box_we && !plane_q && !vert_q;
  assign wt_we   = load_we || (box_we && plane_q && vert_q);
  assign ws_we   = box_we && plane_q && !vert_q;
  assign inv_we  = load_we;

  always_comb begin
    case (state_q)
      ST_IDLE: begin
        waddr     = load_idx_q[AW-1:0];
        raddr     = fetch_idx[AW-1:0];
        img_wdata = load_val;
        wt_wdata  = in_i.sample_valid ? WEIGHT_ONE : '0;
      end
      ST_SCAN, ST_RAT_RD, ST_RAT_CHK, ST_RAT_DIV: begin
        waddr     = cnt_q[AW-1:0];
        raddr     = cnt_q[AW-1:0];
        img_wdata = rat_val;
        wt_wdata  = res_q[WB-1:0];
      end
      default: begin
        waddr     = addr_s;
        raddr     = addr_s;
        img_wdata = res_q[SB-1:0];
        wt_wdata  = res_q[WB-1:0];
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    plane_d      = plane_q;
    vert_d       = vert_q;
    pass_d       = pass_q;
    line_d       = line_q;
    x_d          = x_q;
    base_d       = base_q;
    j_d          = j_q;
    cnt_d        = cnt_q;
    load_idx_d   = load_idx_q;
    read_idx_d   = read_idx_q;
    any_inv_d    = any_inv_q;
    neg_d        = neg_q;
    fetch_last_d = fetch_last_q;
    sum_d        = sum_q;
    a_d          = a_q;
    res_d        = res_q;
    div_start    = 1'b0;
    out_full_d   = out_full_q;
    if (out_o.valid && out_o.ready) begin
      out_full_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (is_fetch) begin
            read_idx_d   = fetch_last ? '0 : fetch_idx + NW'(1);
            fetch_last_d = fetch_last;
            state_d      = ST_FETCH;
          end else begin
            if (load_we) begin
              load_idx_d = load_idx_q + NW'(1);
            end
            if (in_i.load_last) begin
              load_idx_d = '0;
              read_idx_d = '0;
              cnt_d      = '0;
              any_inv_d  = 1'b0;
              state_d    = ST_SCAN;
            end
          end
        end
      end
      ST_FETCH: begin
        out_full_d = 1'b1;
        state_d    = ST_IDLE;
      end
      ST_SCAN: begin
        if (cnt_q != '0) begin
          any_inv_d = any_inv_q | inv_rdata;
        end
        if (cnt_q == n_s - NW'(1)) begin
          state_d = ST_SCAN_LAST;
        end else begin
          cnt_d = cnt_q + NW'(1);
        end
      end
      ST_SCAN_LAST: begin
        any_inv_d = any_inv_q | inv_rdata;
        plane_d   = 1'b0;
        pass_d    = 2'd0;
        vert_d    = 1'b0;
        line_d    = '0;
        base_d    = '0;
        state_d   = ST_LINE;
      end
      ST_LINE: begin
        x_d     = '0;
        state_d = ST_INIT_MUL;
      end
      ST_INIT_MUL: begin
        // first sample stands in for itself and the r cells left of the line
        sum_d   = SW'(signed'({1'b0, rp1})) * SW'(src_v);
        j_d     = (RAD_BITS+1)'(1);
        state_d = (r_s == '0) ? ST_DIV_START : ST_INIT_ACC;
      end
      ST_INIT_ACC: begin
        sum_d = sum_q + SW'(src_v);
        j_d   = j_q + (RAD_BITS+1)'(1);
        if (j_q == {1'b0, r_s}) begin
          state_d = ST_DIV_START;
        end
      end
      ST_DIV_START: begin
        neg_d     = sum_q[SW-1];
        div_start = 1'b1;
        state_d   = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          res_d   = box_res;
          state_d = ST_ADD_RD;
        end
      end
      ST_ADD_RD: begin
        a_d     = src_v;
        state_d = ST_SUB_RD;
      end
      ST_SUB_RD: begin
        // slide the window: add the leading cell, drop the trailing one
        sum_d = sum_q + SW'(a_q) - SW'(src_v);
        if (x_q == last_s) begin
          state_d = ST_LINE_END;
        end else begin
          x_d     = x_q + LW'(1);
          state_d = ST_DIV_START;
        end
      end
      ST_LINE_END: begin
        state_d = ST_LINE;
        if (line_q == lines_s - LW'(1)) begin
          line_d = '0;
          base_d = '0;
          if (!vert_q) begin
            vert_d = 1'b1;
          end else begin
            vert_d = 1'b0;
            if (pass_q == 2'd2) begin
              pass_d = 2'd0;
              if (!plane_q && any_inv_q) begin
                plane_d = 1'b1;
              end else if (plane_q) begin
                cnt_d   = '0;
                state_d = ST_RAT_RD;
              end else begin
                state_d = ST_IDLE;
              end
            end else begin
              pass_d = pass_q + 2'd1;
            end
          end
        end else begin
          line_d = line_q + LW'(1);
          base_d = base_q + (vert_q ? AW'(1) : AW'(wl));
        end
      end
      ST_RAT_RD: begin
        state_d = ST_RAT_CHK;
      end
      ST_RAT_CHK: begin
        if (inv_rdata || wt_rdata == '0) begin
          if (cnt_q == n_s - NW'(1)) begin
            state_d = ST_IDLE;
          end else begin
            cnt_d   = cnt_q + NW'(1);
            state_d = ST_RAT_RD;
          end
        end else begin
          neg_d     = img_rd[SB-1];
          div_start = 1'b1;
          state_d   = ST_RAT_DIV;
        end
      end
      ST_RAT_DIV: begin
        if (div_done) begin
          if (cnt_q == n_s - NW'(1)) begin
            state_d = ST_IDLE;
          end else begin
            cnt_d   = cnt_q + NW'(1);
            state_d = ST_RAT_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      plane_q      <= 1'b0;
      vert_q       <= 1'b0;
      pass_q       <= 2'd0;
      line_q       <= '0;
      x_q          <= '0;
      base_q       <= '0;
      j_q          <= '0;
      cnt_q        <= '0;
      load_idx_q   <= '0;
      read_idx_q   <= '0;
      any_inv_q    <= 1'b0;
      neg_q        <= 1'b0;
      fetch_last_q <= 1'b0;
      out_full_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      plane_q      <= plane_d;
      vert_q       <= vert_d;
      pass_q       <= pass_d;
      line_q       <= line_d;
      x_q          <= x_d;
      base_q       <= base_d;
      j_q          <= j_d;
      cnt_q        <= cnt_d;
      load_idx_q   <= load_idx_d;
      read_idx_q   <= read_idx_d;
      any_inv_q    <= any_inv_d;
      neg_q        <= neg_d;
      fetch_last_q <= fetch_last_d;
      out_full_q   <= out_full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    a_q   <= a_d;
    res_q <= res_d;
    if (state_q == ST_FETCH) begin
      blurred_q  <= inv_rdata ? '0 : img_rd;
      out_ok_q   <= !inv_rdata;
      out_last_q <= fetch_last_q;
    end
  end

  assign in_i.ready      = in_ready;
  assign out_o.valid     = out_full_q;
  assign out_o.blurred   = blurred_q;
  assign out_o.out_valid = out_ok_q;
  assign out_o.out_last  = out_last_q;

  // checks
  a_div_idle_on_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_fetch_fills_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_fetch) |-> ##2 out_full_q)
    else $error("fetch did not produce a result word");

  a_line_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUB_RD) |-> (x_q <= last_s))
    else $error("box position ran past end of line");

endmodule

// ===== sv/gbba_ram.sv =====
// Simple dual-port memory: one write port, one read port with registered data.
module gbba_ram #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 16
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/gbba_div.sv =====
// Radix-2 restoring divider for unsigned operands, one quotient bit a cycle.
module gbba_div #(
  parameter int NUM_W = 41,
  parameter int DEN_W = 18
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy_q, done_q;
  logic [CW-1:0]    cnt_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W:0]   shifted, diff;
  logic             ge;

  always_comb begin
    shifted = {rem_q, quo_q[NUM_W-1]};
    diff    = shifted - {1'b0, den_q};
    ge      = shifted >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the three-pass box blur: directed table, then random rasters.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import gbba_pkg::*;

  localparam int CELLS     = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
  localparam int SBITS     = SAMPLE_BITS_DEF;
  localparam int ONE_W     = 65536;
  localparam int SETTLE    = 40;
  localparam longint LIMIT = 20_000_000;
  localparam int RAND_ITEMS = 600;

  typedef struct {
    logic signed [SBITS-1:0] blurred;
    bit                      ok;
    bit                      last;
  } blur_word_t;

  typedef enum {ROW_CFG, ROW_LOAD, ROW_FETCH} row_kind_e;

  typedef struct {
    row_kind_e kind;
    cfg_reg_e  rg;
    int        val;
    bit        sv;
    bit        last;
    bit        typed;
    int        e_val;
    bit        e_ok;
    bit        e_last;
  } plan_row_t;

  logic clk_i, rst_ni;

  gbba_in_if  in_ch();
  gbba_out_if out_ch();
  gbba_cfg_if cfg_ch();

  gaussian_blur_box_approx DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  // Blur state mirror: planes 0/1 are samples and their scratch, 2/3 weights and theirs.
  int         planes [4][CELLS];
  bit         missing [CELLS];
  int unsigned load_pos, read_pos;
  int unsigned cols_reg, rows_reg, rad [3];

  blur_word_t pending_q[$];
  int         fail_cnt;
  int         items_sent;
  bit         calm, hold_req;

  function automatic int unsigned used_cols();
    if (cols_reg == 0) return 1;
    return (cols_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : cols_reg;
  endfunction

  function automatic int unsigned used_rows();
    if (rows_reg == 0) return 1;
    return (rows_reg > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : rows_reg;
  endfunction

  function automatic longint round_div(longint s, longint d);
    if (s >= 0) return (s + d / 2) / d;
    return -((-s + d / 2) / d);
  endfunction

  function automatic void box_avg_line(int src, int dst, int unsigned base, int unsigned stride,
                                       int unsigned len, int unsigned r);
    longint      d, sum;
    int unsigned j, x, tail, add, sub;
    d    = 2 * longint'(r) + 1;
    tail = len - 1;
    sum  = (longint'(r) + 1) * planes[src][base];
    for (j = 1; j <= r; j++)
      sum += planes[src][base + ((j < tail) ? j : tail) * stride];
    for (x = 0; x < len; x++) begin
      add = x + r + 1;
      sub = (x >= r) ? x - r : 0;
      planes[dst][base + x * stride] = int'(round_div(sum, d));
      if (add > tail) add = tail;
      sum += longint'(planes[src][base + add * stride]) - planes[src][base + sub * stride];
    end
  endfunction

  function automatic void blur_three(int pl, int unsigned w, int unsigned h);
    int unsigned rmax, r, i;
    rmax = (((w < h) ? w : h) - 1) / 2;
    for (int k = 0; k < 3; k++) begin
      r = (rad[k] < rmax) ? rad[k] : rmax;
      for (i = 0; i < h; i++) box_avg_line(pl, pl + 1, i * w, 1, w, r);
      for (i = 0; i < w; i++) box_avg_line(pl + 1, pl, i, w, h, r);
    end
  endfunction

  function automatic void run_blur();
    int unsigned w, h, n;
    bit          holes;
    longint      q, smax, smin;
    w = used_cols();
    h = used_rows();
    n = w * h;
    smax = (longint'(1) << (SBITS - 1)) - 1;
    smin = -smax - 1;
    holes = 0;
    for (int unsigned i = 0; i < n; i++) if (missing[i]) holes = 1;
    blur_three(0, w, h);
    if (!holes) return;
    blur_three(2, w, h);
    for (int unsigned i = 0; i < n; i++) begin
      q = 0;
      if (!missing[i] && planes[2][i] > 0) begin
        q = round_div(longint'(planes[0][i]) * ONE_W, planes[2][i]);
        if (q > smax) q = smax;
        if (q < smin) q = smin;
      end
      planes[0][i] = int'(q);
    end
  endfunction

  // Apply one accepted word to the mirror; returns 1 with the expected result on a fetch.
  function automatic bit blur_step(func_e f, logic signed [SBITS-1:0] s, bit sv, bit last,
                                   output blur_word_t res);
    int unsigned n;
    n = used_cols() * used_rows();
    res = '{default: '0};
    if (f == FUNC_LOAD) begin
      if (load_pos < n) begin
        planes[0][load_pos] = sv ? int'(s) : 0;
        planes[2][load_pos] = sv ? ONE_W : 0;
        missing[load_pos]   = !sv;
        load_pos++;
      end
      if (last) begin
        run_blur();
        load_pos = 0;
        read_pos = 0;
      end
      return 0;
    end
    if (read_pos >= n) read_pos = 0;
    res.blurred = missing[read_pos] ? '0 : planes[0][read_pos][SBITS-1:0];
    res.ok      = !missing[read_pos];
    res.last    = (read_pos == n - 1);
    read_pos    = (read_pos + 1 >= n) ? 0 : read_pos + 1;
    return 1;
  endfunction

  task automatic send_word(func_e f, logic signed [SBITS-1:0] s, bit sv, bit last,
                           bit typed = 0, blur_word_t typed_res = '{default: '0});
    blur_word_t res;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_ch.valid        = 1'b1;
    in_ch.func         = f;
    in_ch.sample       = s;
    in_ch.sample_valid = sv;
    in_ch.load_last    = last;
    do @(posedge clk_i); while (!in_ch.ready);
    if (blur_step(f, s, sv, last, res)) pending_q.push_back(typed ? typed_res : res);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Drain every expected word, wait for the blur run to finish, then settle.
  task automatic wait_idle();
    in_ch.valid = 1'b0;
    in_ch.func  = FUNC_LOAD;
    wait (pending_q.size() == 0);
    @(negedge clk_i);
    while (!in_ch.ready) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e rg, int unsigned val);
    wait_idle();
    cfg_ch.valid = 1'b1;
    cfg_ch.index = rg;
    cfg_ch.data  = val[CFG_DATA_W-1:0];
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (rg)
      REG_WIDTH:  cols_reg = val & 9'h1FF;
      REG_HEIGHT: rows_reg = val & 9'h1FF;
      REG_RAD_A:  rad[0]   = val & 7'h7F;
      REG_RAD_B:  rad[1]   = val & 7'h7F;
      REG_RAD_C:  rad[2]   = val & 7'h7F;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic logic signed [SBITS-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return {1'b0, {(SBITS-1){1'b1}}};
      1: return {1'b1, {(SBITS-1){1'b0}}};
      2: return SBITS'(int'($urandom_range(0, 4095)) - 2048);
      default: return SBITS'($urandom());
    endcase
  endfunction

  plan_row_t plan[] = '{
    '{ROW_CFG,   REG_WIDTH,  1,        0, 0, 0, 0,        0, 0},
    '{ROW_CFG,   REG_HEIGHT, 1,        0, 0, 0, 0,        0, 0},
    '{ROW_CFG,   REG_RAD_A,  127,      0, 0, 0, 0,        0, 0},
    '{ROW_CFG,   REG_RAD_B,  0,        0, 0, 0, 0,        0, 0},
    '{ROW_CFG,   REG_RAD_C,  127,      0, 0, 0, 0,        0, 0},
    '{ROW_LOAD,  REG_WIDTH,  8388607,  1, 1, 0, 0,        0, 0},
    '{ROW_FETCH, REG_WIDTH,  0,        0, 0, 1, 8388607,  1, 1},
    '{ROW_LOAD,  REG_WIDTH,  -8388608, 1, 1, 0, 0,        0, 0},
    '{ROW_FETCH, REG_WIDTH,  0,        0, 0, 1, -8388608, 1, 1},
    '{ROW_FETCH, REG_WIDTH,  0,        0, 0, 1, -8388608, 1, 1},
    '{ROW_LOAD,  REG_WIDTH,  5,        0, 1, 0, 0,        0, 0},
    '{ROW_FETCH, REG_WIDTH,  0,        0, 0, 1, 0,        0, 1},
    '{ROW_LOAD,  REG_WIDTH,  300,      1, 0, 0, 0,        0, 0},
    '{ROW_LOAD,  REG_WIDTH,  77,       1, 1, 0, 0,        0, 0},
    '{ROW_FETCH, REG_WIDTH,  0,        0, 0, 1, 300,      1, 1},
    '{ROW_CFG,   REG_WIDTH,  0,        0, 0, 0, 0,        0, 0},
    '{ROW_LOAD,  REG_WIDTH,  42,       1, 1, 0, 0,        0, 0},
    '{ROW_FETCH, REG_WIDTH,  0,        0, 0, 1, 42,       1, 1},
    '{ROW_CFG,   REG_WIDTH,  3,        0, 0, 0, 0,        0, 0},
    '{ROW_CFG,   REG_HEIGHT, 2,        0, 0, 0, 0,        0, 0},
    '{ROW_CFG,   REG_RAD_A,  1,        0, 0, 0, 0,        0, 0},
    '{ROW_LOAD,  REG_WIDTH,  1000,     1, 0, 0, 0,        0, 0},
    '{ROW_LOAD,  REG_WIDTH,  -700,     1, 0, 0, 0,        0, 0},
    '{ROW_LOAD,  REG_WIDTH,  9999,     0, 0, 0, 0,        0, 0},
    '{ROW_LOAD,  REG_WIDTH,  8388607,  1, 0, 0, 0,        0, 0},
    '{ROW_LOAD,  REG_WIDTH,  -8388608, 1, 0, 0, 0,        0, 0},
    '{ROW_LOAD,  REG_WIDTH,  12,       1, 1, 0, 0,        0, 0},
    '{ROW_FETCH, REG_WIDTH,  0,        0, 0, 0, 0,        0, 0},
    '{ROW_FETCH, REG_WIDTH,  0,        0, 0, 0, 0,        0, 0},
    '{ROW_FETCH, REG_WIDTH,  0,        0, 0, 0, 0,        0, 0},
    '{ROW_FETCH, REG_WIDTH,  0,        0, 0, 0, 0,        0, 0},
    '{ROW_FETCH, REG_WIDTH,  0,        0, 0, 0, 0,        0, 0},
    '{ROW_FETCH, REG_WIDTH,  0,        0, 0, 0, 0,        0, 0}
  };

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    longint cyc;
    cyc = 0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc > LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Result side: random stalls, one long hold-off on request, none in the closing stretch.
  initial begin
    int  burst;
    bit  rdy;
    out_ch.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ch.ready = 1'b0;
        repeat (400) @(negedge clk_i);
        hold_req = 0;
      end else begin
        rdy   = calm || ($urandom_range(0, 3) != 0);
        burst = rdy ? $urandom_range(1, 20) : $urandom_range(1, 12);
        out_ch.ready = rdy;
        repeat (burst - 1) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    blur_word_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected word blurred=%0d ok=%0b last=%0b", $time,
                 out_ch.blurred, out_ch.out_valid, out_ch.out_last);
        fail_cnt++;
      end else begin
        want = pending_q.pop_front();
        if (out_ch.blurred !== want.blurred) begin
          $display("%0t: blurred expected %0d actual %0d", $time, want.blurred, out_ch.blurred);
          fail_cnt++;
        end
        if (out_ch.out_valid !== want.ok) begin
          $display("%0t: out_valid expected %0b actual %0b", $time, want.ok, out_ch.out_valid);
          fail_cnt++;
        end
        if (out_ch.out_last !== want.last) begin
          $display("%0t: out_last expected %0b actual %0b", $time, want.last, out_ch.out_last);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    int unsigned n, w, h, extra, fetches, ph;
    bit          all_ok;
    blur_word_t  tw;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_LOAD;
    in_ch.sample = '0;
    in_ch.sample_valid = 1'b0;
    in_ch.load_last = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_WIDTH;
    cfg_ch.data = '0;
    fail_cnt = 0;
    items_sent = 0;
    calm = 0;
    hold_req = 0;
    load_pos = 0;
    read_pos = 0;
    cols_reg = 256;
    rows_reg = 256;
    rad = '{0, 0, 0};
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_CFG: write_reg(plan[i].rg, plan[i].val);
        ROW_LOAD: send_word(FUNC_LOAD, SBITS'(plan[i].val), plan[i].sv, plan[i].last);
        default: begin
          tw = '{SBITS'(plan[i].e_val), plan[i].e_ok, plan[i].e_last};
          send_word(FUNC_FETCH, '0, 0, 0, plan[i].typed, tw);
        end
      endcase
    end

    ph = 0;
    while (ph < 4 || items_sent < RAND_ITEMS) begin
      // Widest row and tallest column first, then small rasters.
      if (ph == 0) begin
        write_reg(REG_WIDTH, 511);
        write_reg(REG_HEIGHT, 1);
      end else if (ph == 1) begin
        write_reg(REG_WIDTH, 1);
        write_reg(REG_HEIGHT, 256);
      end else begin
        w = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 12);
        h = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 12);
        if ($urandom_range(0, 1)) write_reg(REG_WIDTH, w);
        if ($urandom_range(0, 1)) write_reg(REG_HEIGHT, h);
      end
      if (ph < 3 || $urandom_range(0, 1)) begin
        write_reg(REG_RAD_A, ($urandom_range(0, 5) == 0) ? 127 : $urandom_range(0, 5));
        write_reg(REG_RAD_B, ($urandom_range(0, 5) == 0) ? 127 : $urandom_range(0, 5));
        write_reg(REG_RAD_C, ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, 5));
      end
      if (items_sent > RAND_ITEMS - 150) calm = 1;
      n      = used_cols() * used_rows();
      all_ok = $urandom_range(0, 1);
      extra  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 0;
      for (int unsigned i = 0; i < n + extra; i++)
        send_word(FUNC_LOAD, pick_sample(), all_ok || ($urandom_range(0, 4) != 0),
                  i == n + extra - 1);
      fetches = (n > 40) ? $urandom_range(20, 40) : n + $urandom_range(0, n);
      // keep offering fetches long enough for the hold-off to back up the input
      if (ph == 2) begin
        hold_req = 1;
        fetches  = fetches + 30;
      end
      if (ph == 3) fetches = fetches + 4;
      for (int unsigned i = 0; i < fetches; i++) begin
        if (ph == 3 && i == fetches / 2) begin
          in_ch.valid = 1'b0;
          wait (pending_q.size() == 0);
          @(negedge clk_i);
        end
        send_word(FUNC_FETCH, '0, 0, 0);
      end
      ph++;
    end

    in_ch.valid = 1'b0;
    wait (pending_q.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
    if (fail_cnt == 0 && pending_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== gaussian_blur_box_approx.f =====
sv/gbba_pkg.sv
sv/gbba_if.sv
sv/gbba_ram.sv
sv/gbba_div.sv
sv/gaussian_blur_box_approx.sv
test/testbench.sv
